/* rtl/core/cbmt_pkg.sv */
// Shared types for the counter bank with maximum tracking.
package cbmt_pkg;

    // Operation codes carried on the input side band.
    typedef enum logic [1:0] {
        OP_INC = 2'd0,
        OP_DEC = 2'd1,
        OP_RST = 2'd2,
        OP_QRY = 2'd3
    } t_op;

    // Commands from the controller to the datapath, one per controller state.
    typedef struct packed {
        logic clr;       // clearing pass, one memory entry per cycle
        logic cap;       // capture the input request
        logic rd_cnt;    // read the selected counter
        logic calc;      // new counter value, counter write, histogram reads
        logic wr_a;      // decrement the old value's histogram bucket
        logic wr_b;      // increment the new value's histogram bucket
        logic walk;      // step the downward histogram walk
        logic rd_max;    // read the histogram bucket of the maximum
        logic load_out;  // load the output register
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clr_done;
        logic need_walk;
        logic walk_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/cbmt_ctrl.sv */
// Controller state machine for the counter bank with maximum tracking.
module cbmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  cbmt_pkg::t_sts i_sts,
    output cbmt_pkg::t_cmd o_cmd
);
    import cbmt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDC,
        S_RDH,
        S_WRA,
        S_WRB,
        S_WALK,
        S_RDM,
        S_FIN
    } t_state;

    t_state r_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR: if (i_sts.clr_done) r_state <= S_IDLE;
                S_IDLE:  if (i_s_tvalid) r_state <= S_RDC;
                S_RDC:   r_state <= S_RDH;
                S_RDH:   r_state <= S_WRA;
                S_WRA:   r_state <= S_WRB;
                S_WRB:   r_state <= i_sts.need_walk ? S_WALK : S_RDM;
                S_WALK:  if (i_sts.walk_done) r_state <= S_RDM;
                S_RDM:   r_state <= S_FIN;
                S_FIN:   if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Command decode from the current state, the request valid and the status.
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr      = (r_state == S_CLEAR);
        o_cmd.cap      = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.rd_cnt   = (r_state == S_RDC);
        o_cmd.calc     = (r_state == S_RDH);
        o_cmd.wr_a     = (r_state == S_WRA);
        o_cmd.wr_b     = (r_state == S_WRB);
        o_cmd.walk     = (r_state == S_WALK);
        o_cmd.rd_max   = (r_state == S_RDM);
        o_cmd.load_out = (r_state == S_FIN) && i_sts.out_free;
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

/* rtl/core/cbmt_dpath.sv */
// Datapath: counter memory, histogram memory, maximum register and output register.
module cbmt_dpath #(
    parameter int NUM_COUNTERS = 64,
    parameter int COUNT_BITS   = 8,
    parameter int IDX_W        = $clog2(NUM_COUNTERS),
    parameter int HC_W         = $clog2(NUM_COUNTERS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cbmt_pkg::t_cmd        i_cmd,
    output cbmt_pkg::t_sts        o_sts,
    input  logic [1:0]            i_operation,
    input  logic [IDX_W-1:0]      i_counter_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COUNT_BITS-1:0] o_counter_value,
    output logic [COUNT_BITS-1:0] o_max_value,
    output logic [HC_W-1:0]       o_max_count,
    output logic                  o_saturated
);
    import cbmt_pkg::*;

    localparam int HIST_DEPTH = 1 << COUNT_BITS;
    localparam int CLR_LEN    = (HIST_DEPTH > NUM_COUNTERS) ? HIST_DEPTH : NUM_COUNTERS;
    localparam int CLR_W      = $clog2(CLR_LEN);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Memories.
    logic [COUNT_BITS-1:0] r_cmem [NUM_COUNTERS];
    logic [HC_W-1:0]       r_hmem [HIST_DEPTH];

    // Request and working registers.
    t_op                   r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic [COUNT_BITS-1:0] r_old;
    logic [COUNT_BITS-1:0] r_new;
    logic                  r_sat;
    logic                  r_chg;
    logic [HC_W-1:0]       r_ha_q;
    logic [HC_W-1:0]       r_hb_q;
    logic [HC_W-1:0]       r_hb1;
    logic                  r_need_walk;
    logic [COUNT_BITS-1:0] r_max;
    logic [COUNT_BITS-1:0] r_walk;
    logic [COUNT_BITS-1:0] r_walk_d;
    logic                  r_wv;
    logic [CLR_W-1:0]      r_clr_addr;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_val;
    logic [COUNT_BITS-1:0] r_out_max;
    logic [HC_W-1:0]       r_out_cnt;
    logic                  r_out_sat;

    logic                  in_range;
    logic [COUNT_BITS-1:0] old_val;
    logic [COUNT_BITS-1:0] n_new;
    logic                  n_sat;
    logic                  n_chg;
    logic [COUNT_BITS-1:0] ha_addr;
    logic                  clr_hist_en;
    logic                  clr_cnt_en;
    logic                  walk_done;

    assign in_range    = {1'b0, r_idx} < (IDX_W + 1)'(NUM_COUNTERS);
    assign clr_hist_en = {1'b0, r_clr_addr} < (CLR_W + 1)'(HIST_DEPTH);
    assign clr_cnt_en  = {1'b0, r_clr_addr} < (CLR_W + 1)'(NUM_COUNTERS);
    assign old_val     = in_range ? r_cnt_q : '0;

    // New counter value and saturation flag for the captured operation.
    always_comb begin
        n_new = old_val;
        n_sat = 1'b0;
        n_chg = 1'b0;
        case (r_op)
            OP_INC: begin
                if (old_val == CNT_MAX) begin
                    n_sat = 1'b1;
                end else begin
                    n_new = old_val + 1'b1;
                    n_chg = 1'b1;
                end
            end
            OP_DEC: begin
                if (old_val != '0) begin
                    n_new = old_val - 1'b1;
                    n_chg = 1'b1;
                end
            end
            OP_RST: begin
                if (old_val != '0) begin
                    n_new = '0;
                    n_chg = 1'b1;
                end
            end
            default: ;
        endcase
        if (!in_range) begin
            n_new = '0;
            n_sat = 1'b0;
            n_chg = 1'b0;
        end
    end

    // Address of the first histogram read port.
    always_comb begin
        if (i_cmd.walk) begin
            ha_addr = r_walk;
        end else if (i_cmd.rd_max) begin
            ha_addr = r_max;
        end else begin
            ha_addr = old_val;
        end
    end

    // The walk stops at the first occupied bucket, or at zero.
    assign walk_done = r_wv && ((r_ha_q != '0) || (r_walk_d == '0));

    // Counter memory: clearing writes, update write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && clr_cnt_en) begin
            r_cmem[r_clr_addr[IDX_W-1:0]] <= '0;
        end else if (i_cmd.calc && n_chg) begin
            r_cmem[r_idx] <= n_new;
        end
        if (i_cmd.rd_cnt && in_range) begin
            r_cnt_q <= r_cmem[r_idx];
        end
    end

    // Histogram memory: one write port and two registered read ports.
    // The first read port only loads when its data is needed, so the count
    // of the maximum stays put while the result waits for the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && clr_hist_en) begin
            r_hmem[r_clr_addr[COUNT_BITS-1:0]] <=
                (r_clr_addr == '0) ? HC_W'(NUM_COUNTERS) : '0;
        end else if (i_cmd.wr_a && r_chg) begin
            r_hmem[r_old] <= r_ha_q - 1'b1;
        end else if (i_cmd.wr_b && r_chg) begin
            r_hmem[r_new] <= r_hb1;
        end
        if (i_cmd.calc || i_cmd.walk || i_cmd.rd_max) begin
            r_ha_q <= r_hmem[ha_addr];
        end
        r_hb_q <= r_hmem[n_new];
    end

    // Request capture and per-item working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= t_op'(i_operation);
            r_idx <= i_counter_index;
        end
        if (i_cmd.calc) begin
            r_old <= old_val;
            r_new <= n_new;
            r_sat <= n_sat;
            r_chg <= n_chg;
        end
        if (i_cmd.wr_a) begin
            r_hb1       <= r_hb_q + 1'b1;
            r_need_walk <= r_chg && (r_op == OP_RST) && (r_old == r_max) &&
                           (r_ha_q == HC_W'(1));
        end
        // Downward walk, one bucket per cycle; r_walk_d trails r_walk to match the registered read.
        if (i_cmd.wr_b) begin
            r_walk <= r_old - 1'b1;
            r_wv   <= 1'b0;
        end else if (i_cmd.walk) begin
            r_walk_d <= r_walk;
            r_wv     <= 1'b1;
            if (r_walk != '0) begin
                r_walk <= r_walk - 1'b1;
            end
        end
    end

    // Running maximum and clearing address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_max      <= '0;
            end
            // An increment can only raise the maximum by one step.
            if (i_cmd.wr_a && r_chg && (r_op == OP_INC) && (r_new > r_max)) begin
                r_max <= r_new;
            end
            // A decrement of the lone maximum counter lands one below it.
            if (i_cmd.wr_a && r_chg && (r_op == OP_DEC) && (r_old == r_max) &&
                (r_ha_q == HC_W'(1))) begin
                r_max <= r_new;
            end
            if (i_cmd.walk && walk_done) begin
                r_max <= r_walk_d;
            end
        end
    end

    // Output register, free when empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_val <= r_new;
            r_out_max <= r_max;
            r_out_cnt <= r_ha_q;
            r_out_sat <= r_sat;
        end
    end

    assign o_sts.clr_done  = (r_clr_addr == CLR_W'(CLR_LEN - 1));
    assign o_sts.need_walk = r_need_walk;
    assign o_sts.walk_done = walk_done;
    assign o_sts.out_free  = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_counter_value = r_out_val;
    assign o_max_value     = r_out_max;
    assign o_max_count     = r_out_cnt;
    assign o_saturated     = r_out_sat;

endmodule

/* rtl/core/counter_bank_max_tracker.sv */
// Top level of the counter bank with maximum tracking.
//
// A bank of NUM_COUNTERS counters of COUNT_BITS bits each. Every request names a
// counter and an operation (increment with saturation, decrement stopping at
// zero, reset to zero, or query) and returns one result: the counter's new
// value, the largest value in the bank, how many counters hold it, and a flag
// for a refused increment. Requests are handled one at a time: each one goes
// through the read-modify-write of the counter memory, the two bucket updates
// through the single write port of the histogram memory and the read of the
// maximum's bucket before the next request can be accepted. Resetting the only
// counter at the maximum adds a downward walk of the histogram, one bucket per
// cycle. After reset a clearing pass over the counter and histogram memories
// runs before the first request is taken. A finished result waits in the
// output register while the next request is accepted; the next result is held
// back until that register is taken.
module counter_bank_max_tracker #(
    parameter int  NUM_COUNTERS = 64,
    parameter int  COUNT_BITS   = 8,
    localparam int IDX_W        = $clog2(NUM_COUNTERS),
    localparam int HC_W         = $clog2(NUM_COUNTERS + 1),
    localparam int IN_TDATA_W   = ((IDX_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((2 * COUNT_BITS + HC_W + 1 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // counter_index
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // operation
    input  logic [1:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // counter_value, max_value, max_count, saturated
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);
    import cbmt_pkg::*;

    t_cmd                  cmd;
    t_sts                  sts;
    logic [COUNT_BITS-1:0] counter_value;
    logic [COUNT_BITS-1:0] max_value;
    logic [HC_W-1:0]       max_count;
    logic                  saturated;

    // Controller.
    cbmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    cbmt_dpath #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .COUNT_BITS   (COUNT_BITS),
        .IDX_W        (IDX_W),
        .HC_W         (HC_W)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_s_tuser),
        .i_counter_index (i_s_tdata[IDX_W-1:0]),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_counter_value (counter_value),
        .o_max_value     (max_value),
        .o_max_count     (max_count),
        .o_saturated     (saturated)
    );

    // Pack the result fields, lowest field first, zero padded.
    assign o_m_tdata = OUT_TDATA_W'({saturated, max_count, max_value, counter_value});

endmodule

/* rtl/core/cbmt_checker.sv */
// Port-level checks for the counter bank with maximum tracking, bound to the top level.
module cbmt_checker #(
    parameter int NUM_COUNTERS = 64,
    parameter int COUNT_BITS   = 8,
    parameter int HC_W         = $clog2(NUM_COUNTERS + 1),
    parameter int OUT_TDATA_W  = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);
    localparam int MAXV_LO = COUNT_BITS;
    localparam int CNT_LO  = 2 * COUNT_BITS;
    localparam int SAT_BIT = 2 * COUNT_BITS + HC_W;

    logic [COUNT_BITS-1:0] f_val;
    logic [COUNT_BITS-1:0] f_max;
    logic [HC_W-1:0]       f_cnt;
    logic                  f_sat;

    assign f_val = o_m_tdata[COUNT_BITS-1:0];
    assign f_max = o_m_tdata[MAXV_LO +: COUNT_BITS];
    assign f_cnt = o_m_tdata[CNT_LO +: HC_W];
    assign f_sat = o_m_tdata[SAT_BIT];

    // The clearing pass keeps requests out right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("request taken during the clearing pass");

    // One request at a time: ready drops after an accepted request.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request accepted while one is in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // The maximum is held by at least one counter and bounds the reported value.
    a_max_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (f_cnt != '0) && (f_val <= f_max))
        else $error("maximum inconsistent with the result");

    // A refused increment means the counter and the maximum are at the top.
    a_sat_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && f_sat |-> (f_val == {COUNT_BITS{1'b1}}) &&
                                (f_max == {COUNT_BITS{1'b1}}))
        else $error("saturation flagged below the counter maximum");

endmodule

bind counter_bank_max_tracker cbmt_checker #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNT_BITS   (COUNT_BITS),
    .HC_W         (HC_W),
    .OUT_TDATA_W  (OUT_TDATA_W)
) u_cbmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* verif/testbench.sv */
// Self-checking testbench for the counter bank with maximum tracking.
module testbench;
    import cbmt_pkg::*;

    localparam int NUM_CTRS      = 64;
    localparam int HIST_SIZE     = 256;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int DIRECTED_ROWS = 13;
    localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
    // Request latency plus the longest downward histogram walk.
    localparam int DRAIN_CYCLES  = 300;
    // Room for the expected results still in flight.
    localparam int EXP_DEPTH     = 16;

    // One result, packed as on o_m_tdata with counter_value in the low byte.
    typedef struct packed {
        logic       saturated;
        logic [6:0] max_count;
        logic [7:0] max_value;
        logic [7:0] counter_value;
    } t_bank_result;

    // One directed request with an optional hand-written expectation.
    typedef struct packed {
        t_op          op;
        logic [5:0]   idx;
        logic         typed;
        t_bank_result want;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // counter_index
    logic [7:0]  i_s_tdata;
    // operation
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // counter_value, max_value, max_count, saturated
    logic [23:0] o_m_tdata;

    // Shadow copy of the bank used to predict every result without a hand-written expectation.
    logic [7:0]   bank_cnt [NUM_CTRS];
    int unsigned  bank_hist [HIST_SIZE];
    logic [7:0]   bank_max;

    // Expected results in order, written at acceptance and read at each result.
    t_bank_result exp_fifo [EXP_DEPTH];
    int           exp_wr;
    int           exp_rd;
    int           error_count;
    int           sent_count;
    int           idle_phase;
    int           source_idle_pct;
    int           sink_idle_pct;

    // Rows: operation, index, typed, {saturated, max_count, max_value, counter_value}.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_QRY, 6'd0,  1'b1, '{1'b0, 7'd64, 8'd0, 8'd0}},
        '{OP_INC, 6'd63, 1'b1, '{1'b0, 7'd1,  8'd1, 8'd1}},
        '{OP_INC, 6'd63, 1'b1, '{1'b0, 7'd1,  8'd2, 8'd2}},
        '{OP_INC, 6'd0,  1'b1, '{1'b0, 7'd1,  8'd2, 8'd1}},
        '{OP_INC, 6'd0,  1'b1, '{1'b0, 7'd2,  8'd2, 8'd2}},
        '{OP_QRY, 6'd21, 1'b1, '{1'b0, 7'd2,  8'd2, 8'd0}},
        '{OP_DEC, 6'd63, 1'b1, '{1'b0, 7'd1,  8'd2, 8'd1}},
        '{OP_RST, 6'd0,  1'b0, '0},
        '{OP_DEC, 6'd42, 1'b1, '{1'b0, 7'd1,  8'd1, 8'd0}},
        '{OP_RST, 6'd21, 1'b1, '{1'b0, 7'd1,  8'd1, 8'd0}},
        '{OP_INC, 6'd42, 1'b1, '{1'b0, 7'd2,  8'd1, 8'd1}},
        '{OP_RST, 6'd63, 1'b1, '{1'b0, 7'd1,  8'd1, 8'd0}},
        '{OP_DEC, 6'd42, 1'b0, '0}
    };

    counter_bank_max_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow bank and returns the result it causes.
    function automatic t_bank_result apply_bank_op(t_op op, logic [5:0] idx);
        t_bank_result r;
        logic [7:0]   v;
        logic [7:0]   old;
        int           w;
        v = bank_cnt[idx];
        old = v;
        r.saturated = 1'b0;
        case (op)
            OP_INC: begin
                if (v == 8'hFF) begin
                    r.saturated = 1'b1;
                end else begin
                    v = v + 8'd1;
                    if (v > bank_max) bank_max = v;
                end
            end
            OP_DEC: begin
                if (v != 8'd0) v = v - 8'd1;
            end
            OP_RST: begin
                v = 8'd0;
            end
            default: begin
            end
        endcase
        bank_hist[old]--;
        bank_hist[v]++;
        bank_cnt[idx] = v;
        // The last counter at the maximum moved down: walk to the next filled bucket.
        if (v < old && old == bank_max && bank_hist[old] == 0) begin
            w = old;
            while (w > 0 && bank_hist[w] == 0) w--;
            bank_max = w[7:0];
        end
        r.counter_value = v;
        r.max_value     = bank_max;
        r.max_count     = bank_hist[bank_max][6:0];
        return r;
    endfunction

    // Draws an operation with the given share of increments, the rest spread evenly.
    function automatic t_op pick_op(int inc_pct);
        int d;
        d = $urandom_range(99);
        if (d < inc_pct) return OP_INC;
        case ($urandom_range(2))
            0: return OP_DEC;
            1: return OP_RST;
            default: return OP_QRY;
        endcase
    endfunction

    // Drives one request and records its expected result once it is accepted.
    task automatic send_request(t_op op, logic [5:0] idx, logic typed, t_bank_result want);
        t_bank_result got;
        int           p;
        @(negedge i_clk);
        p = (sent_count * 3) / TOTAL_ITEMS;
        if (p > 2) p = 2;
        // At each change of idling pattern, hold off until the block has drained.
        if (p != idle_phase) begin
            i_s_tvalid = 1'b0;
            while (exp_wr != exp_rd) @(negedge i_clk);
            idle_phase = p;
            source_idle_pct = (p == 0) ? 19 : (p == 1) ? 58 : 0;
            sink_idle_pct   = (p == 0) ? 58 : (p == 1) ? 19 : 0;
        end
        while ($urandom_range(99) < source_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, idx};
        i_s_tuser  = op;
        do @(posedge i_clk); while (!o_s_tready);
        got = apply_bank_op(op, idx);
        exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : got;
        exp_wr++;
        sent_count++;
    endtask

    // Random requests in segments: ramps to saturation, hot sets, sweeps and noise.
    task automatic run_random(int count);
        int         kind;
        int         n;
        int         k;
        int         stop;
        logic [5:0] r;
        logic [5:0] hot [4];
        stop = sent_count + count;
        kind = 0;
        while (sent_count < stop) begin
            if (kind == 0 || kind == 1) begin
                // Push one counter to its ceiling and past it, then often drop it.
                r = 6'($urandom_range(63));
                n = 255 + $urandom_range(1, 6);
                for (k = 0; k < n && sent_count < stop; k++) begin
                    if ($urandom_range(99) < 10)
                        send_request(pick_op(25), 6'($urandom_range(63)), 1'b0, '0);
                    send_request(OP_INC, r, 1'b0, '0);
                end
                if (sent_count < stop) begin
                    case ($urandom_range(2))
                        0: send_request(OP_RST, r, 1'b0, '0);
                        1: send_request(OP_DEC, r, 1'b0, '0);
                        default: send_request(OP_QRY, r, 1'b0, '0);
                    endcase
                end
            end else if (kind <= 5) begin
                // A few counters worked hard, so several share the maximum.
                for (k = 0; k < 4; k++) hot[k] = 6'($urandom_range(63));
                for (k = 0; k < 40 && sent_count < stop; k++)
                    send_request(pick_op(50), hot[$urandom_range(3)], 1'b0, '0);
            end else if (kind == 6) begin
                // Increment every counter once.
                for (k = 0; k < NUM_CTRS && sent_count < stop; k++)
                    send_request(OP_INC, 6'(k), 1'b0, '0);
            end else begin
                for (k = 0; k < 30 && sent_count < stop; k++)
                    send_request(t_op'($urandom_range(3)), 6'($urandom_range(63)), 1'b0, '0);
            end
            kind = $urandom_range(9);
        end
    endtask

    // Result side: random back-pressure.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Reports one field that differs from its expectation.
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_bank_result got;
        t_bank_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                error_count++;
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("counter_value", want.counter_value, got.counter_value);
                check_field("max_value", want.max_value, got.max_value);
                check_field("max_count", want.max_count, got.max_count);
                check_field("saturated", want.saturated, got.saturated);
            end
        end
    end

    // Main sequence: reset, directed table, random part, drain and verdict.
    initial begin
        int i;
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = OP_INC;
        exp_wr          = 0;
        exp_rd          = 0;
        error_count     = 0;
        sent_count      = 0;
        idle_phase      = 0;
        source_idle_pct = 19;
        sink_idle_pct   = 58;
        for (i = 0; i < NUM_CTRS; i++) bank_cnt[i] = 8'd0;
        for (i = 0; i < HIST_SIZE; i++) bank_hist[i] = 0;
        bank_hist[0] = NUM_CTRS;
        bank_max = 8'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].op, directed_rows[i].idx,
                         directed_rows[i].typed, directed_rows[i].want);
        run_random(RANDOM_ITEMS);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
